// ===== rtl/sdn_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sdn_pkg
// shared field widths and the memory command type of the direction
// number generator
// ----------------------------------------------------------------------------
package sdn_pkg;

    // input beat fields
    localparam int unsigned IDX_W      = 10;
    localparam int unsigned DEG_W      = 5;
    localparam int unsigned COEF_W     = 15;
    localparam int unsigned IN_TDATA_W = 32;

    // output beat fields
    localparam int unsigned BIDX_W = 5;

    // odd seed 3 + 2*index, largest 2049
    localparam int unsigned ODD_W = 12;

    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } t_mem_cmd;

endpackage
`default_nettype wire

// ===== rtl/sdn_dir_mem.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sdn_dir_mem
// recent direction numbers, one write and one read port, registered read
// ----------------------------------------------------------------------------
module sdn_dir_mem #(
    parameter int unsigned WIDTH = 30,
    parameter int unsigned AW    = 4
) (
    input  wire                    i_clk,
    input  sdn_pkg::t_mem_cmd      i_cmd,
    input  wire  [AW-1:0]          i_wr_addr,
    input  wire  [WIDTH-1:0]       i_wr_data,
    input  wire  [AW-1:0]          i_rd_addr,
    output logic [WIDTH-1:0]       o_rd_data
);
    import sdn_pkg::*;

    logic [WIDTH-1:0] r_mem [2**AW];

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule
`default_nettype wire

// ===== rtl/sdn_seq.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sdn_seq
// per-number sequencer: seeds the first degree numbers, then walks the
// lags through the memory read port and folds them into an accumulator
// ----------------------------------------------------------------------------
module sdn_seq #(
    parameter int unsigned DIRECTION_BITS = 30,
    parameter int unsigned MAX_DEGREE     = 16,
    parameter int unsigned AW             = 4,
    parameter int unsigned JW             = 5
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_in_valid,
    output logic                         o_in_ready,
    input  wire  [sdn_pkg::IDX_W-1:0]    i_dim_index,
    input  wire  [sdn_pkg::DEG_W-1:0]    i_poly_degree,
    input  wire  [sdn_pkg::COEF_W-1:0]   i_poly_bits,
    output sdn_pkg::t_mem_cmd            o_mem_cmd,
    output logic [AW-1:0]                o_wr_addr,
    output logic [AW-1:0]                o_rd_addr,
    input  wire  [DIRECTION_BITS-1:0]    i_rd_data,
    input  wire                          i_out_free,
    output logic                         o_res_load,
    output logic [JW-1:0]                o_res_index,
    output logic                         o_res_last,
    output logic [DIRECTION_BITS-1:0]    o_res_value
);
    import sdn_pkg::*;

    localparam int unsigned LIMIT = (MAX_DEGREE < DIRECTION_BITS) ? MAX_DEGREE
                                                                  : DIRECTION_BITS;
    localparam int unsigned JLAST = DIRECTION_BITS - 1;
    localparam int unsigned CW    = (JW > DEG_W) ? JW : DEG_W;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_NEXT  = 3'd1;
    localparam logic [2:0] S_READ  = 3'd2;
    localparam logic [2:0] S_DRAIN = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;

    logic [2:0]                r_state, n_state;
    logic [JW-1:0]             r_j, n_j;
    logic                      r_rd_valid, n_rd_valid;
    logic [DEG_W-1:0]          r_deg, n_deg;
    logic [COEF_W-1:0]         r_coef, n_coef;
    logic [ODD_W-1:0]          r_odd, n_odd;
    logic [DEG_W-1:0]          r_lag, n_lag;
    logic [DEG_W-1:0]          r_rd_lag, n_rd_lag;
    logic [DIRECTION_BITS-1:0] r_acc, n_acc;

    logic [DEG_W-1:0]                deg_in;
    logic [JW-1:0]                   shamt;
    logic [DIRECTION_BITS+ODD_W-1:0] seed_wide;
    logic [DIRECTION_BITS-1:0]       init_v;
    logic [DEG_W-1:0]                coef_pos;
    logic [COEF_W-1:0]               coef_sh;
    logic                            coef_sel;
    logic [DIRECTION_BITS-1:0]       term;
    logic                            is_last;

    // degree zero acts as one, large degrees saturate
    always_comb begin
        if (i_poly_degree == '0) begin
            deg_in = DEG_W'(1);
        end else if (i_poly_degree > DEG_W'(LIMIT)) begin
            deg_in = DEG_W'(LIMIT);
        end else begin
            deg_in = i_poly_degree;
        end
    end

    // low j+1 bits of the odd seed placed at the top of the word
    assign shamt     = JW'(JLAST) - r_j;
    assign seed_wide = {{DIRECTION_BITS{1'b0}}, r_odd} << shamt;
    assign init_v    = DIRECTION_BITS'(seed_wide);

    // coefficient for lag l sits at bit deg-1-l
    assign coef_pos = r_deg - DEG_W'(1) - r_rd_lag;
    assign coef_sh  = r_coef >> coef_pos;
    assign coef_sel = (coef_pos < DEG_W'(COEF_W)) && coef_sh[0];

    always_comb begin
        if (r_rd_lag == r_deg) begin
            term = i_rd_data ^ (i_rd_data >> r_deg);
        end else if (coef_sel) begin
            term = i_rd_data;
        end else begin
            term = '0;
        end
    end

    assign is_last = (r_j == JW'(JLAST));

    always_comb begin
        n_state    = r_state;
        n_j        = r_j;
        n_deg      = r_deg;
        n_coef     = r_coef;
        n_odd      = r_odd;
        n_lag      = r_lag;
        n_rd_lag   = r_rd_lag;
        n_rd_valid = 1'b0;
        n_acc      = r_acc;
        o_in_ready = 1'b0;
        o_mem_cmd  = '0;
        o_res_load = 1'b0;
        o_rd_addr  = AW'(r_j) - AW'(r_lag);
        o_wr_addr  = AW'(r_j);

        // fold in the word returned by the read issued in the cycle before
        if (r_rd_valid) begin
            n_acc = r_acc ^ term;
        end

        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_deg   = deg_in;
                    n_coef  = i_poly_bits;
                    n_odd   = ODD_W'({i_dim_index, 1'b1}) + ODD_W'(2);
                    n_j     = '0;
                    n_state = S_NEXT;
                end
            end
            S_NEXT: begin
                if (CW'(r_j) < CW'(r_deg)) begin
                    n_acc   = init_v;
                    n_state = S_DONE;
                end else begin
                    n_acc   = '0;
                    n_lag   = r_deg;
                    n_state = S_READ;
                end
            end
            S_READ: begin
                o_mem_cmd.rd_en = 1'b1;
                n_rd_valid      = 1'b1;
                n_rd_lag        = r_lag;
                n_lag           = r_lag - DEG_W'(1);
                if (r_lag == DEG_W'(1)) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                if (i_out_free) begin
                    o_mem_cmd.wr_en = 1'b1;
                    o_res_load      = 1'b1;
                    if (is_last) begin
                        n_j     = '0;
                        n_state = S_IDLE;
                    end else begin
                        n_j     = r_j + JW'(1);
                        n_state = S_NEXT;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_res_index = r_j;
    assign o_res_last  = is_last;
    assign o_res_value = r_acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_j        <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_j        <= n_j;
            r_rd_valid <= n_rd_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_deg    <= n_deg;
        r_coef   <= n_coef;
        r_odd    <= n_odd;
        r_lag    <= n_lag;
        r_rd_lag <= n_rd_lag;
        r_acc    <= n_acc;
    end

    // memory write and read never share a cycle, so no read sees a stale entry
    a_no_rw_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_mem_cmd.wr_en && o_mem_cmd.rd_en))
        else $error("direction memory read and write in the same cycle");

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && i_in_valid) |=> (r_state == S_NEXT && r_j == '0))
        else $error("accepted dimension did not start at number zero");

    a_read_returns: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_READ) |=> r_rd_valid)
        else $error("issued read not followed by read data");

    a_lag_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_READ) |-> (r_lag != '0))
        else $error("lag walk reached zero while reading");

    a_last_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_load && o_res_last) |=> (r_state == S_IDLE))
        else $error("sequencer did not return to idle after the last number");

endmodule
`default_nettype wire

// ===== rtl/sobol_direction_numbers.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sobol_direction_numbers
// Sobol direction number generator, one dimension in, all its numbers out
// ----------------------------------------------------------------------------
// usage
//   s_axis carries one dimension per beat: index, polynomial degree and the
//   interior coefficient bits. m_axis returns DIRECTION_BITS beats for it,
//   bit_index 0 first, tlast on the final number.
//   the first degree numbers come straight from the odd seed 3+2*index; each
//   later one reads the number degree places back and every number that a
//   set coefficient selects from a small direction memory, one read a cycle
// sequencing
//   after the input beat is taken, the first result beat passes through
//   S_NEXT, S_DONE and the output register; a seeded number goes through
//   S_NEXT and S_DONE, a recursive one through S_NEXT, an S_READ per lag,
//   S_DRAIN and S_DONE, as the single read port walks the lags in turn
//   one dimension is worked on at a time; s_axis_tready is high only idle
// reset and stalls
//   i_rst_n (synchronous) returns the sequencer to idle and drops m_axis_tvalid
//   a result sits in the output register; while m_axis_tready is low the
//   sequencer holds the next number, and the next input beat can be taken
//   while the last number of a dimension still waits
// ----------------------------------------------------------------------------
module sobol_direction_numbers #(
    parameter int unsigned DIRECTION_BITS = 30,
    parameter int unsigned MAX_DEGREE     = 16
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          s_axis_tvalid,
    output logic                         s_axis_tready,
    // dim_index[9:0], poly_degree[14:10], poly_bits[29:15], zero pad
    input  wire  [sdn_pkg::IN_TDATA_W-1:0] s_axis_tdata,
    output logic                         m_axis_tvalid,
    input  wire                          m_axis_tready,
    // bit_index[4:0], direction[DIRECTION_BITS+4:5], zero pad
    output logic [((sdn_pkg::BIDX_W + DIRECTION_BITS + 7) / 8) * 8 - 1:0] m_axis_tdata,
    output logic                         m_axis_tlast
);
    import sdn_pkg::*;

    localparam int unsigned OUT_W = ((BIDX_W + DIRECTION_BITS + 7) / 8) * 8;
    // memory deep enough for the longest lag
    localparam int unsigned AW    = (MAX_DEGREE > 1) ? $clog2(MAX_DEGREE) : 1;
    localparam int unsigned JW    = $clog2(DIRECTION_BITS);

    // input beat unpacking
    logic [IDX_W-1:0]  in_index;
    logic [DEG_W-1:0]  in_degree;
    logic [COEF_W-1:0] in_coef;

    assign in_index  = s_axis_tdata[IDX_W-1:0];
    assign in_degree = s_axis_tdata[IDX_W+DEG_W-1:IDX_W];
    assign in_coef   = s_axis_tdata[IDX_W+DEG_W+COEF_W-1:IDX_W+DEG_W];

    t_mem_cmd                  mem_cmd;
    logic [AW-1:0]             wr_addr;
    logic [AW-1:0]             rd_addr;
    logic [DIRECTION_BITS-1:0] rd_data;
    logic                      out_free;
    logic                      res_load;
    logic [JW-1:0]             res_index;
    logic                      res_last;
    logic [DIRECTION_BITS-1:0] res_value;

    // output register: free when empty or being drained this cycle
    logic             r_out_valid;
    logic [OUT_W-1:0] r_out_data;
    logic             r_out_last;

    assign out_free = !r_out_valid || m_axis_tready;

    sdn_seq #(
        .DIRECTION_BITS (DIRECTION_BITS),
        .MAX_DEGREE     (MAX_DEGREE),
        .AW             (AW),
        .JW             (JW)
    ) u_seq (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (s_axis_tvalid),
        .o_in_ready    (s_axis_tready),
        .i_dim_index   (in_index),
        .i_poly_degree (in_degree),
        .i_poly_bits   (in_coef),
        .o_mem_cmd     (mem_cmd),
        .o_wr_addr     (wr_addr),
        .o_rd_addr     (rd_addr),
        .i_rd_data     (rd_data),
        .i_out_free    (out_free),
        .o_res_load    (res_load),
        .o_res_index   (res_index),
        .o_res_last    (res_last),
        .o_res_value   (res_value)
    );

    // the finished number is written back in the same cycle it is emitted
    sdn_dir_mem #(
        .WIDTH (DIRECTION_BITS),
        .AW    (AW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_cmd     (mem_cmd),
        .i_wr_addr (wr_addr),
        .i_wr_data (res_value),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_load) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    // bit_index wraps at its field width
    always_ff @(posedge i_clk) begin
        if (res_load) begin
            r_out_data <= OUT_W'({res_value, BIDX_W'(res_index)});
            r_out_last <= res_last;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tlast  = r_out_last;

endmodule
`default_nettype wire
